/* hdl/two_sensor_passage_speed_detector_defines.svh */
// Assertion helpers for the passage speed detector.
`ifndef TWO_SENSOR_PASSAGE_SPEED_DETECTOR_DEFINES_SVH
`define TWO_SENSOR_PASSAGE_SPEED_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TSPD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tspd: same-cycle check failed");

// Next-cycle implication.
`define TSPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tspd: next-cycle check failed");

`endif

/* hdl/tspd_pkg.sv */
package tspd_pkg;

  // Field widths
  localparam int unsigned SENSE_W   = 2;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned SPEED_W   = 24;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned HOLD_W    = 10;

  // Register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [SCALE_W-1:0]   SCALE_RST   = 24'd10000;
  localparam logic [HOLD_W-1:0]    HOLD_RST    = 10'd50;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_SCALE   = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;

  // Sensor patterns
  localparam logic [SENSE_W-1:0] SNS_NONE = 2'd0;
  localparam logic [SENSE_W-1:0] SNS_A    = 2'd1;
  localparam logic [SENSE_W-1:0] SNS_B    = 2'd2;
  localparam logic [SENSE_W-1:0] SNS_BOTH = 2'd3;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_FWD = 2'd0;
  localparam logic [DIR_W-1:0] DIR_REV = 2'd1;
  localparam logic [DIR_W-1:0] DIR_UNK = 2'd2;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // Passage phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_EDGE    = 4'b0010,
    PH_BOTH    = 4'b0100,
    PH_THROUGH = 4'b1000
  } phase_e;

  // Divider states
  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Divider control from the sequencer
  typedef struct packed {
    logic start;
    logic take;
  } div_ctl_t;

endpackage

/* hdl/two_sensor_passage_speed_detector.sv */
// A report passes from the completing sample through the divider's run and done
//   states into the output register; a zero count skips the run state.
// Samples are taken one per cycle while the divider is idle; after a report
//   s_axis_tready_o stays low while the divider runs, longer while the output is held.
// Reset (rst_ni low, asynchronous): phase idle, counters clear, registers take
//   their reset values, no result pending.
`include "two_sensor_passage_speed_detector_defines.svh"

module two_sensor_passage_speed_detector #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [1:0] sensor_bits, [7:2] zero
  // Report stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [1:0] direction, [25:2] speed_mm_s,
                                        // [41:26] elapsed_ticks, [47:42] zero
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tspd_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Registers
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [SCALE_W-1:0]   scale_q;
  logic [HOLD_W-1:0]    hold_cfg_q;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  // Passage state
  phase_e                phase_q, phase_d;
  logic [SENSE_W-1:0]    first_q, first_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [HOLD_W-1:0]     hold_q, hold_d;
  logic                  report;

  // Pending result fields and output register
  logic [DIR_W-1:0]     res_dir_q;
  logic [ELAPSED_W-1:0] res_elapsed_q;
  logic                 out_vld_q;
  logic [DIR_W-1:0]     out_dir_q;
  logic [SPEED_W-1:0]   out_speed_q;
  logic [ELAPSED_W-1:0] out_elapsed_q;

  logic                  s_fire;
  logic [SENSE_W-1:0]    sns;
  logic [COUNT_BITS-1:0] tick_inc;
  logic [CMP_W-1:0]      tick_ext;
  logic                  inc_over, cur_over;
  logic [DIR_W-1:0]      dir_now;
  logic                  load_out;

  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [SPEED_W-1:0]  div_quo;

  // Register port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TIMEOUT_RST;
      scale_q    <= SCALE_RST;
      hold_cfg_q <= HOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TIMEOUT: timeout_q  <= pwdata[TIMEOUT_W-1:0];
        REG_SCALE:   scale_q    <= pwdata[SCALE_W-1:0];
        REG_HOLD:    hold_cfg_q <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIMEOUT: prdata = {{(32-TIMEOUT_W){1'b0}}, timeout_q};
      REG_SCALE:   prdata = {{(32-SCALE_W){1'b0}}, scale_q};
      REG_HOLD:    prdata = {{(32-HOLD_W){1'b0}}, hold_cfg_q};
      default:     prdata = '0;
    endcase
  end

  // Sample intake: held off while a division is in flight
  assign s_axis_tready_o = !div_sts.busy;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign sns             = s_axis_tdata_i[SENSE_W-1:0];

  // Saturating count and timeout compares
  assign tick_inc = (tick_q == COUNT_MAX) ? tick_q : tick_q + 1'b1;
  assign inc_over = CMP_W'(tick_inc) > CMP_W'(timeout_q);
  assign cur_over = CMP_W'(tick_q) > CMP_W'(timeout_q);
  assign tick_ext = CMP_W'(tick_q);

  always_comb begin
    case (first_q)
      SNS_A:   dir_now = DIR_FWD;
      SNS_B:   dir_now = DIR_REV;
      default: dir_now = DIR_UNK;
    endcase
  end

  // Phase sequencer, one step per accepted sample
  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    tick_d  = tick_q;
    hold_d  = hold_q;
    report  = 1'b0;
    if (s_fire) begin
      if (hold_q != '0) begin
        hold_d = hold_q - 1'b1;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            tick_d = '0;
            if (sns != SNS_NONE) begin
              first_d = sns;
              phase_d = PH_EDGE;
            end
          end
          PH_EDGE: begin
            if (sns == first_q) begin
              tick_d = tick_inc;
              if (inc_over) begin
                phase_d = PH_IDLE;
              end
            end else if (sns == SNS_BOTH) begin
              phase_d = PH_BOTH;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_BOTH: begin
            if ((sns & first_q) == SNS_NONE) begin
              phase_d = PH_THROUGH;
            end else begin
              tick_d = tick_inc;
            end
          end
          PH_THROUGH: begin
            if (sns == SNS_NONE) begin
              report  = 1'b1;
              phase_d = PH_IDLE;
              hold_d  = hold_cfg_q;
            end else if (cur_over) begin
              phase_d = PH_IDLE;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      first_q <= SNS_NONE;
      tick_q  <= '0;
      hold_q  <= '0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
      tick_q  <= tick_d;
      hold_q  <= hold_d;
    end
  end

  // Fields of a report wait here while the divider runs
  always_ff @(posedge clk_i) begin
    if (report) begin
      res_dir_q     <= dir_now;
      res_elapsed_q <= tick_ext[ELAPSED_W-1:0];
    end
  end

  // Speed division
  assign load_out      = div_sts.done && (!out_vld_q || m_axis_tready_i);
  assign div_ctl.start = report;
  assign div_ctl.take  = load_out;

  tspd_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_ctl),
    .scale_i  (scale_q),
    .divisor_i(tick_q),
    .sts_o    (div_sts),
    .quo_o    (div_quo)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_dir_q     <= res_dir_q;
      out_speed_q   <= div_quo;
      out_elapsed_q <= res_elapsed_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_elapsed_q, out_speed_q, out_dir_q};

  // A report only comes from a sample outside the holdoff window
  `TSPD_ASSERT_SAME(a_no_report_in_hold, clk_i, rst_ni, report, hold_q == '0 && s_fire)
  // A report always puts the divider to work
  `TSPD_ASSERT_NEXT(a_report_busy, clk_i, rst_ni, report, div_sts.busy && hold_q == hold_cfg_q)
  // The output register only fills from a finished division
  `TSPD_ASSERT_SAME(a_out_from_div, clk_i, rst_ni, load_out, div_sts.done)

endmodule

/* hdl/tspd_div.sv */
`include "two_sensor_passage_speed_detector_defines.svh"

// Restoring divider, one quotient bit per cycle: quo = scale / divisor.
// A zero divisor gives the saturated maximum at once.
module tspd_div #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tspd_pkg::div_ctl_t            ctl_i,
  input  logic [tspd_pkg::SCALE_W-1:0]  scale_i,
  input  logic [COUNT_BITS-1:0]         divisor_i,
  output tspd_pkg::div_sts_t            sts_o,
  output logic [tspd_pkg::SPEED_W-1:0]  quo_o
);
  import tspd_pkg::*;

  localparam int unsigned CNT_W = $clog2(SPEED_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SPEED_W - 1);

  div_state_e             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SPEED_W-1:0]     quo_q, quo_d;
  logic [COUNT_BITS-1:0]  rem_q, rem_d;
  logic [COUNT_BITS-1:0]  dvs_q, dvs_d;
  logic [COUNT_BITS:0]    rem_sh;
  logic [COUNT_BITS:0]    rem_sub;
  logic                   ge;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign rem_sh  = {rem_q, quo_q[SPEED_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (ctl_i.start) begin
          dvs_d = divisor_i;
          rem_d = '0;
          cnt_d = '0;
          if (divisor_i == '0) begin
            quo_d   = SPEED_MAX;
            state_d = DIV_DONE;
          end else begin
            quo_d   = scale_i;
            state_d = DIV_RUN;
          end
        end
      end
      DIV_RUN: begin
        rem_d = ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        quo_d = {quo_q[SPEED_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (ctl_i.take) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy = (state_q != DIV_IDLE);
  assign sts_o.done = (state_q == DIV_DONE);
  assign quo_o      = quo_q;

  // A start is only issued to an idle divider
  `TSPD_ASSERT_SAME(a_start_idle, clk_i, rst_ni, ctl_i.start, state_q == DIV_IDLE)
  // The run phase always lasts until the last step
  `TSPD_ASSERT_NEXT(a_run_to_done, clk_i, rst_ni,
                    state_q == DIV_RUN && cnt_q == LAST_STEP, state_q == DIV_DONE)
  // The remainder stays below the divisor while running
  `TSPD_ASSERT_SAME(a_rem_bound, clk_i, rst_ni, state_q == DIV_RUN, rem_q < dvs_q)

endmodule
